@@ rtl/core/fcta_pkg.sv @@
// Shared types, widths and constants for the forward collision TTC alert.
// No dependencies; every other file but fcta_delay takes names from here by scope.
package fcta_pkg;

  localparam int NREG         = 8;
  localparam int CFG_W        = 16;
  localparam int DIFF_W       = 17;   // position difference once range test has passed
  localparam int D2_W         = 33;   // squared distance carried to the square root
  localparam int ROOT_W       = 17;
  localparam int VEC_W        = 41;   // vectoring datapath, north/east scaled by 2^20
  localparam int COS_W        = 34;   // rotation datapath, Q30
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 17;
  localparam int DIV_STEPS    = 17;   // overflow test plus sixteen quotient bits
  localparam int NUM_W        = 27;   // distance * 1000
  localparam int DEN_W        = 49;   // approach speed, Q30 cm/s
  localparam int APP_W        = 51;

  localparam logic signed [COS_W-1:0] CORDIC_GAIN = COS_W'(652032874);
  localparam logic signed [APP_W-1:0] APP_MIN     = APP_W'(64'd50 << 30);
  localparam logic [13:0]             STILL_SPEED = 14'd100;
  localparam logic [50:0]             MIN_D2      = 51'd2500;

  typedef enum logic [2:0] {
    REG_CONE_FAR,
    REG_CONE_NEAR,
    REG_NEAR_RANGE,
    REG_HEADING,
    REG_BRAKE,
    REG_TTC_CRIT,
    REG_TTC_WARN,
    REG_TTC_INFO
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BRAKE,
    KIND_TTC
  } kind_t;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_INFO,
    LVL_WARN,
    LVL_CRIT
  } level_t;

  // Control and pass-through fields that travel alongside the datapath.
  typedef struct packed {
    logic               vld;
    logic               rej;
    logic               brake;
    kind_t              kind;
    logic [15:0]        oh;
    logic [15:0]        ph;
    logic [13:0]        os;
    logic [13:0]        ps;
    logic [ROOT_W-1:0]  d;
    logic [31:0]        ident;
  } side_t;

  // Magnitude of a binary angle difference, folded into 0..32768.
  function automatic logic [16:0] angle_mag16(input logic [15:0] a);
    logic [16:0] res;
    if (a <= 16'h8000) begin
      res = {1'b0, a};
    end else begin
      res = 17'h10000 - {1'b0, a};
    end
    return res;
  endfunction

  // Arctangent of 2^-i, 2^32 per turn.
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/forward_collision_ttc_alert.sv @@
// Top level of the forward collision TTC alert pipeline.
// Depends on fcta_pkg, fcta_delay, fcta_isqrt, fcta_cordic_vec, fcta_cordic_cos, fcta_div.
//
// Use: each input word describes the own vehicle and one peer; each accepted word gives
// exactly one result word, in order. Both channels are valid/ready; a word moves at a
// clock edge with valid and ready high. A word with no alert comes out as all zeros.
//
// Depth: two chains of 30 CORDIC stages (bearing, then line-of-sight cosines) and the
// 17-stage divider make up most of the pipeline between input and output register.
// Throughput: one word per cycle while the output is not stalled; every stage holds
// one word and bubbles travel as invalid words.
//
// Stall: all stages share one enable, high while the output register is empty or being
// taken. When the receiver holds off out_ready with a result waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
//
// Reset (rst_n low, synchronous): clears all valid bits and loads the register defaults.
// Configuration: cfg_we writes cfg_data into register cfg_index at once; write only
// while no word is in flight.
module forward_collision_ttc_alert #(
  parameter int MAX_RANGE_CM = 10000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [23:0]   in_own_x,
  input  logic signed [23:0]   in_own_y,
  input  logic [15:0]          in_own_heading,
  input  logic [13:0]          in_own_speed,
  input  logic signed [23:0]   in_peer_x,
  input  logic signed [23:0]   in_peer_y,
  input  logic [15:0]          in_peer_heading,
  input  logic [13:0]          in_peer_speed,
  input  logic signed [13:0]   in_peer_accel,
  input  logic [31:0]          in_peer_ident,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_alert_kind,
  output logic [1:0]           out_alert_level,
  output logic [15:0]          out_ttc_ms,
  output logic [13:0]          out_distance_cm,
  output logic [31:0]          out_alert_peer_ident,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam logic [50:0] MaxSq = 51'(longint'(MAX_RANGE_CM) * longint'(MAX_RANGE_CM));
  localparam int DW = fcta_pkg::DIFF_W;

  // ---------------------------------------------------------------- configuration
  logic [15:0]        cone_far_r;
  logic [15:0]        cone_near_r;
  logic [13:0]        near_range_r;
  logic [15:0]        heading_r;
  logic signed [13:0] brake_r;
  logic [15:0]        ttc_crit_r;
  logic [15:0]        ttc_warn_r;
  logic [15:0]        ttc_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cone_far_r   <= 16'd2731;
      cone_near_r  <= 16'd8192;
      near_range_r <= 14'd1000;
      heading_r    <= 16'd8192;
      brake_r      <= -14'sd400;
      ttc_crit_r   <= 16'd1500;
      ttc_warn_r   <= 16'd3000;
      ttc_info_r   <= 16'd5000;
    end else if (cfg_we) begin
      case (fcta_pkg::reg_idx_t'(cfg_index))
        fcta_pkg::REG_CONE_FAR:   cone_far_r   <= cfg_data;
        fcta_pkg::REG_CONE_NEAR:  cone_near_r  <= cfg_data;
        fcta_pkg::REG_NEAR_RANGE: near_range_r <= cfg_data[13:0];
        fcta_pkg::REG_HEADING:    heading_r    <= cfg_data;
        fcta_pkg::REG_BRAKE:      brake_r      <= signed'(cfg_data[13:0]);
        fcta_pkg::REG_TTC_CRIT:   ttc_crit_r   <= cfg_data;
        fcta_pkg::REG_TTC_WARN:   ttc_warn_r   <= cfg_data;
        fcta_pkg::REG_TTC_INFO:   ttc_info_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic adv;
  logic out_valid_r;

  // advance whenever the output register is free or being emptied
  assign adv      = out_ready || !out_valid_r;
  assign in_ready = adv;

  // ---------------------------------------------------------------- stage 1: differences
  fcta_pkg::side_t    side1_r, side1_nxt;
  logic signed [24:0] dx1_r, dy1_r;

  always_comb begin
    side1_nxt       = '0;
    side1_nxt.vld   = in_valid;
    // a moving peer on a different course is dropped
    side1_nxt.rej   = (in_peer_speed >= fcta_pkg::STILL_SPEED) &&
                      (fcta_pkg::angle_mag16(in_own_heading - in_peer_heading) >
                       {1'b0, heading_r});
    side1_nxt.brake = in_peer_accel < brake_r;
    side1_nxt.kind  = fcta_pkg::KIND_NONE;
    side1_nxt.oh    = in_own_heading;
    side1_nxt.ph    = in_peer_heading;
    side1_nxt.os    = in_own_speed;
    side1_nxt.ps    = in_peer_speed;
    side1_nxt.ident = in_peer_ident;
  end

  // ---------------------------------------------------------------- stage 2: squares
  fcta_pkg::side_t    side2_r;
  logic signed [24:0] dx2_r, dy2_r;
  logic [49:0]        sqx2_r, sqy2_r;
  logic signed [49:0] sqx_nxt, sqy_nxt;

  assign sqx_nxt = dx1_r * dx1_r;
  assign sqy_nxt = dy1_r * dy1_r;

  // ---------------------------------------------------------------- stage 3: range test
  fcta_pkg::side_t                side3_r, side3_nxt;
  logic [fcta_pkg::D2_W-1:0]      d2_3_r;
  logic signed [DW-1:0]           e3_r, n3_r;
  logic [50:0]                    d2_nxt;

  always_comb begin
    d2_nxt        = 51'(sqx2_r) + 51'(sqy2_r);
    side3_nxt     = side2_r;
    // drop peers nearer than half a metre or beyond range
    side3_nxt.rej = side2_r.rej || (d2_nxt < fcta_pkg::MIN_D2) || (d2_nxt > MaxSq);
  end

  // ---------------------------------------------------------------- bearing and distance
  logic [31:0]                  bearing;
  logic [fcta_pkg::ROOT_W-1:0]  root_raw, root_al;
  fcta_pkg::side_t              side_v;

  fcta_cordic_vec u_vec (
    .clk       (clk),
    .en        (adv),
    .east_i    (e3_r),
    .north_i   (n3_r),
    .bearing_o (bearing)
  );

  fcta_isqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .sq_i   (d2_3_r),
    .root_o (root_raw)
  );

  fcta_delay #(
    .Width (fcta_pkg::ROOT_W),
    .Depth (fcta_pkg::CORDIC_STEPS - fcta_pkg::SQRT_STEPS)
  ) u_root_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (root_raw),
    .q_o   (root_al)
  );

  fcta_delay #(
    .Width ($bits(fcta_pkg::side_t)),
    .Depth (fcta_pkg::CORDIC_STEPS)
  ) u_side_v (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (side3_r),
    .q_o   (side_v)
  );

  // ---------------------------------------------------------------- stage 4: cone test
  fcta_pkg::side_t side4_r, side4_nxt;
  logic [31:0]     a1_4_r, a2_4_r;
  logic [15:0]     b16;
  logic [15:0]     cone;

  always_comb begin
    logic [31:0] br;
    br    = bearing + 32'h0000_8000;
    b16   = br[31:16];
    // widen the cone at near range
    cone  = (root_al < {3'b0, near_range_r}) ? cone_near_r : cone_far_r;
    side4_nxt     = side_v;
    side4_nxt.d   = root_al;
    side4_nxt.rej = side_v.rej || (fcta_pkg::angle_mag16(b16 - side_v.oh) > {1'b0, cone});
  end

  // ---------------------------------------------------------------- line-of-sight cosines
  logic signed [fcta_pkg::COS_W-1:0] c1, c2;
  logic                              n1, n2;
  fcta_pkg::side_t                   side_c;

  fcta_cordic_cos u_cos_own (
    .clk     (clk),
    .en      (adv),
    .angle_i (a1_4_r),
    .cos_o   (c1),
    .neg_o   (n1)
  );

  fcta_cordic_cos u_cos_peer (
    .clk     (clk),
    .en      (adv),
    .angle_i (a2_4_r),
    .cos_o   (c2),
    .neg_o   (n2)
  );

  fcta_delay #(
    .Width ($bits(fcta_pkg::side_t)),
    .Depth (fcta_pkg::CORDIC_STEPS)
  ) u_side_c (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (side4_r),
    .q_o   (side_c)
  );

  // ---------------------------------------------------------------- stage 5: speed products
  fcta_pkg::side_t    side5_r;
  logic signed [48:0] p1_5_r, p2_5_r;
  logic               n1_5_r, n2_5_r;
  logic signed [48:0] p1_nxt, p2_nxt;

  assign p1_nxt = $signed({1'b0, side_c.os}) * c1;
  assign p2_nxt = $signed({1'b0, side_c.ps}) * c2;

  // ---------------------------------------------------------------- stage 6: approach, kind
  fcta_pkg::side_t                 side6_r, side6_nxt;
  logic [fcta_pkg::DEN_W-1:0]      app6_r;
  logic [fcta_pkg::NUM_W-1:0]      num6_r;
  logic signed [fcta_pkg::APP_W-1:0] app;

  always_comb begin
    logic signed [fcta_pkg::APP_W-1:0] t1;
    logic signed [fcta_pkg::APP_W-1:0] t2;
    t1  = n1_5_r ? -fcta_pkg::APP_W'(p1_5_r) : fcta_pkg::APP_W'(p1_5_r);
    t2  = n2_5_r ? -fcta_pkg::APP_W'(p2_5_r) : fcta_pkg::APP_W'(p2_5_r);
    app = t1 - t2;
    side6_nxt = side5_r;
    if (side5_r.brake) begin
      side6_nxt.kind = (app > 0) ? fcta_pkg::KIND_BRAKE : fcta_pkg::KIND_NONE;
    end else begin
      side6_nxt.kind = (app > fcta_pkg::APP_MIN) ? fcta_pkg::KIND_TTC : fcta_pkg::KIND_NONE;
    end
    side6_nxt.rej = side5_r.rej || (side6_nxt.kind == fcta_pkg::KIND_NONE);
  end

  // ---------------------------------------------------------------- TTC divider
  logic [15:0]     ttc;
  fcta_pkg::side_t side_d;

  fcta_div u_div (
    .clk   (clk),
    .en    (adv),
    .num_i (num6_r),
    .den_i (app6_r),
    .ttc_o (ttc)
  );

  fcta_delay #(
    .Width ($bits(fcta_pkg::side_t)),
    .Depth (fcta_pkg::DIV_STEPS)
  ) u_side_d (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (side6_r),
    .q_o   (side_d)
  );

  // ---------------------------------------------------------------- output stage
  fcta_pkg::level_t level;
  logic [1:0]       kind_r;
  logic [1:0]       level_r;
  logic [15:0]      ttc_r;
  logic [13:0]      dist_r;
  logic [31:0]      ident_r;
  logic             drop;

  always_comb begin
    if (ttc < ttc_crit_r) begin
      level = fcta_pkg::LVL_CRIT;
    end else if (ttc < ttc_warn_r) begin
      level = fcta_pkg::LVL_WARN;
    end else if (ttc < ttc_info_r) begin
      level = fcta_pkg::LVL_INFO;
    end else begin
      level = fcta_pkg::LVL_NONE;
    end
    drop = side_d.rej || (level == fcta_pkg::LVL_NONE);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r     <= '0;
      side2_r     <= '0;
      side3_r     <= '0;
      side4_r     <= '0;
      side5_r     <= '0;
      side6_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      side1_r     <= side1_nxt;
      side2_r     <= side1_r;
      side3_r     <= side3_nxt;
      side4_r     <= side4_nxt;
      side5_r     <= side_c;
      side6_r     <= side6_nxt;
      out_valid_r <= side_d.vld;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r  <= 25'(in_peer_x) - 25'(in_own_x);
      dy1_r  <= 25'(in_peer_y) - 25'(in_own_y);
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      sqx2_r <= unsigned'(sqx_nxt);
      sqy2_r <= unsigned'(sqy_nxt);
      d2_3_r <= d2_nxt[fcta_pkg::D2_W-1:0];
      e3_r   <= dx2_r[DW-1:0];
      n3_r   <= dy2_r[DW-1:0];
      a1_4_r <= {side_v.oh, 16'b0} - bearing;
      a2_4_r <= {side_v.ph, 16'b0} - bearing;
      p1_5_r <= p1_nxt;
      p2_5_r <= p2_nxt;
      n1_5_r <= n1;
      n2_5_r <= n2;
      app6_r <= app[fcta_pkg::DEN_W-1:0];
      num6_r <= fcta_pkg::NUM_W'(side5_r.d) * fcta_pkg::NUM_W'(1000);
      // zero every field of a word without alert
      if (drop) begin
        kind_r  <= fcta_pkg::KIND_NONE;
        level_r <= fcta_pkg::LVL_NONE;
        ttc_r   <= '0;
        dist_r  <= '0;
        ident_r <= '0;
      end else begin
        kind_r  <= side_d.kind;
        level_r <= level;
        ttc_r   <= ttc;
        dist_r  <= (side_d.d > fcta_pkg::ROOT_W'(16383)) ? 14'h3FFF : side_d.d[13:0];
        ident_r <= side_d.ident;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_alert_kind       = kind_r;
  assign out_alert_level      = level_r;
  assign out_ttc_ms           = ttc_r;
  assign out_distance_cm      = dist_r;
  assign out_alert_peer_ident = ident_r;

endmodule

@@ rtl/core/fcta_delay.sv @@
// Shift line that holds sideband words level with a datapath unit.
// Stand-alone; advances only on the shared pipeline enable.
module fcta_delay #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] line_r [Depth];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Depth; i++) begin
        line_r[i] <= '0;
      end
    end else if (en) begin
      line_r[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q_o = line_r[Depth-1];

endmodule

@@ rtl/core/fcta_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Uses fcta_pkg widths.
module fcta_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [fcta_pkg::D2_W-1:0]    sq_i,
  output logic [fcta_pkg::ROOT_W-1:0]  root_o
);

  localparam int N = fcta_pkg::SQRT_STEPS;
  localparam int W = fcta_pkg::D2_W + 1;

  logic [W-1:0] v_r [N];
  logic [W-1:0] r_r [N];
  logic [W-1:0] v_in [N];
  logic [W-1:0] r_in [N];
  logic [W-1:0] v_nxt [N];
  logic [W-1:0] r_nxt [N];

  always_comb begin
    logic [W-1:0] bitv;
    logic [W-1:0] trial;
    v_in[0] = W'(sq_i);
    r_in[0] = '0;
    for (int k = 1; k < N; k++) begin
      v_in[k] = v_r[k-1];
      r_in[k] = r_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      bitv  = W'(1) << (2 * (N - 1 - k));
      trial = r_in[k] + bitv;
      if (v_in[k] >= trial) begin
        v_nxt[k] = v_in[k] - trial;
        r_nxt[k] = (r_in[k] >> 1) + bitv;
      end else begin
        v_nxt[k] = v_in[k];
        r_nxt[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign root_o = r_r[N-1][fcta_pkg::ROOT_W-1:0];

endmodule

@@ rtl/core/fcta_cordic_vec.sv @@
// Pipelined vectoring CORDIC: bearing of (east, north), 2^32 per turn.
// Uses fcta_pkg widths and arctangent table.
module fcta_cordic_vec (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [fcta_pkg::DIFF_W-1:0] east_i,
  input  logic signed [fcta_pkg::DIFF_W-1:0] north_i,
  output logic [31:0]                        bearing_o
);

  localparam int N  = fcta_pkg::CORDIC_STEPS;
  localparam int W  = fcta_pkg::VEC_W;
  localparam int DW = fcta_pkg::DIFF_W;

  logic signed [W-1:0] x_r [N];
  logic signed [W-1:0] y_r [N];
  logic [31:0]         z_r [N];
  logic signed [W-1:0] x_in [N];
  logic signed [W-1:0] y_in [N];
  logic [31:0]         z_in [N];
  logic signed [W-1:0] x_nxt [N];
  logic signed [W-1:0] y_nxt [N];
  logic [31:0]         z_nxt [N];

  always_comb begin
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    x0 = {{(W-DW-20){north_i[DW-1]}}, north_i, 20'b0};
    y0 = {{(W-DW-20){east_i[DW-1]}}, east_i, 20'b0};
    z_in[0] = '0;
    // fold the rear half-plane forward
    if (x0 < 0) begin
      x0      = -x0;
      y0      = -y0;
      z_in[0] = 32'h8000_0000;
    end
    x_in[0] = x0;
    y_in[0] = y0;
    for (int i = 1; i < N; i++) begin
      x_in[i] = x_r[i-1];
      y_in[i] = y_r[i-1];
      z_in[i] = z_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      xs = x_in[i] >>> i;
      ys = y_in[i] >>> i;
      if (y_in[i] > 0) begin
        x_nxt[i] = x_in[i] + ys;
        y_nxt[i] = y_in[i] - xs;
        z_nxt[i] = z_in[i] + fcta_pkg::atan_at(5'(i));
      end else begin
        x_nxt[i] = x_in[i] - ys;
        y_nxt[i] = y_in[i] + xs;
        z_nxt[i] = z_in[i] - fcta_pkg::atan_at(5'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign bearing_o = z_r[N-1];

endmodule

@@ rtl/core/fcta_cordic_cos.sv @@
// Pipelined rotation CORDIC: cosine of a binary angle, Q30, sign kept apart.
// Uses fcta_pkg widths, gain and arctangent table.
module fcta_cordic_cos (
  input  logic                              clk,
  input  logic                              en,
  input  logic [31:0]                       angle_i,
  output logic signed [fcta_pkg::COS_W-1:0] cos_o,
  output logic                              neg_o
);

  localparam int N = fcta_pkg::CORDIC_STEPS;
  localparam int W = fcta_pkg::COS_W;

  logic signed [W-1:0] x_r [N];
  logic signed [W-1:0] y_r [N];
  logic signed [W-1:0] z_r [N];
  logic                neg_r [N];
  logic signed [W-1:0] x_in [N];
  logic signed [W-1:0] y_in [N];
  logic signed [W-1:0] z_in [N];
  logic                neg_in [N];
  logic signed [W-1:0] x_nxt [N];
  logic signed [W-1:0] y_nxt [N];
  logic signed [W-1:0] z_nxt [N];

  always_comb begin
    logic [31:0]         a;
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] at;
    a         = angle_i;
    neg_in[0] = 1'b0;
    // rear half: rotate by half a turn and negate the result
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a         = a - 32'h8000_0000;
      neg_in[0] = 1'b1;
    end
    x_in[0] = fcta_pkg::CORDIC_GAIN;
    y_in[0] = '0;
    z_in[0] = {{(W-32){a[31]}}, a};
    for (int i = 1; i < N; i++) begin
      x_in[i]   = x_r[i-1];
      y_in[i]   = y_r[i-1];
      z_in[i]   = z_r[i-1];
      neg_in[i] = neg_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      xs = x_in[i] >>> i;
      ys = y_in[i] >>> i;
      at = W'(fcta_pkg::atan_at(5'(i)));
      if (z_in[i] >= 0) begin
        x_nxt[i] = x_in[i] - ys;
        y_nxt[i] = y_in[i] + xs;
        z_nxt[i] = z_in[i] - at;
      end else begin
        x_nxt[i] = x_in[i] + ys;
        y_nxt[i] = y_in[i] - xs;
        z_nxt[i] = z_in[i] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      neg_r <= neg_in;
    end
  end

  assign cos_o = x_r[N-1];
  assign neg_o = neg_r[N-1];

endmodule

@@ rtl/core/fcta_div.sv @@
// Pipelined restoring divider for TTC: floor(num * 2^30 / den), saturated to 16 bits.
// Uses fcta_pkg widths.
module fcta_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [fcta_pkg::NUM_W-1:0]  num_i,
  input  logic [fcta_pkg::DEN_W-1:0]  den_i,
  output logic [15:0]                 ttc_o
);

  localparam int N  = fcta_pkg::DIV_STEPS;
  localparam int RW = fcta_pkg::NUM_W + 30;
  localparam int DW = fcta_pkg::DEN_W;
  localparam int CW = DW + 16;

  logic [RW-1:0] rem_r [N];
  logic [DW-1:0] den_r [N];
  logic [15:0]   q_r   [N];
  logic          ovf_r [N];
  logic [RW-1:0] rem_nxt [N];
  logic [DW-1:0] den_nxt [N];
  logic [15:0]   q_nxt   [N];
  logic          ovf_nxt [N];

  always_comb begin
    logic [CW-1:0] sub;
    rem_nxt[0] = {num_i, 30'b0};
    den_nxt[0] = den_i;
    q_nxt[0]   = '0;
    // quotient of 2^16 or more saturates
    ovf_nxt[0] = {{(CW-RW){1'b0}}, rem_nxt[0]} >= {den_i, 16'b0};
    for (int k = 1; k < N; k++) begin
      sub        = {16'b0, den_r[k-1]} << (N - 1 - k);
      den_nxt[k] = den_r[k-1];
      ovf_nxt[k] = ovf_r[k-1];
      if ({{(CW-RW){1'b0}}, rem_r[k-1]} >= sub) begin
        rem_nxt[k] = rem_r[k-1] - RW'(sub);
        q_nxt[k]   = q_r[k-1] | (16'd1 << (N - 1 - k));
      end else begin
        rem_nxt[k] = rem_r[k-1];
        q_nxt[k]   = q_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign ttc_o = ovf_r[N-1] ? 16'hFFFF : q_r[N-1];

endmodule

@@ rtl/core/fcta_checker.sv @@
// Port-level checks for forward_collision_ttc_alert, attached by the bind below.
// Depends on fcta_pkg codes and the top-level port list.
module fcta_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [23:0] in_own_x,
  input logic signed [23:0] in_own_y,
  input logic [15:0]        in_own_heading,
  input logic [13:0]        in_own_speed,
  input logic signed [23:0] in_peer_x,
  input logic signed [23:0] in_peer_y,
  input logic [15:0]        in_peer_heading,
  input logic [13:0]        in_peer_speed,
  input logic signed [13:0] in_peer_accel,
  input logic [31:0]        in_peer_ident,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_alert_kind,
  input logic [1:0]         out_alert_level,
  input logic [15:0]        out_ttc_ms,
  input logic [13:0]        out_distance_cm,
  input logic [31:0]        out_alert_peer_ident,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [15:0]        cfg_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ttc_ms) && $stable(out_alert_kind))
    else $error("result word changed under stall");

  // a word without alert carries nothing
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert_kind == fcta_pkg::KIND_NONE |->
      out_alert_level == fcta_pkg::LVL_NONE && out_ttc_ms == 16'd0 &&
      out_distance_cm == 14'd0 && out_alert_peer_ident == 32'd0)
    else $error("non-alert word carries data");

  // kind and level agree on whether there is an alert
  a_kind_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert_kind != fcta_pkg::KIND_NONE |->
      out_alert_level != fcta_pkg::LVL_NONE &&
      (out_alert_kind == fcta_pkg::KIND_BRAKE || out_alert_kind == fcta_pkg::KIND_TTC))
    else $error("alert kind without level");

  // alerts only past the minimum range, and intake tracks the output register
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert_kind != fcta_pkg::KIND_NONE |-> out_distance_cm >= 14'd50)
    else $error("alert inside minimum range");

  a_intake: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("intake not tied to output stage");

endmodule

bind forward_collision_ttc_alert fcta_checker u_fcta_checker (.*);

@@ tb/tb_forward_collision_ttc_alert.sv @@
// Self-checking testbench for the forward collision TTC alert pipeline.
// Depends on fcta_pkg and forward_collision_ttc_alert; carries its own alert predictor.
module tb_forward_collision_ttc_alert;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 90;     // outlasts the pipeline depth
  localparam int RAND_PER_PHASE = 215;

  // Arctangent of 2^-i, 2^32 per turn.
  localparam longint ATAN_STEP [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  typedef struct {
    logic signed [23:0] ox, oy;
    logic [15:0]        oh;
    logic [13:0]        os;
    logic signed [23:0] px, py;
    logic [15:0]        ph;
    logic [13:0]        ps;
    logic signed [13:0] pa;
    logic [31:0]        ident;
  } encounter_t;

  typedef struct packed {
    fcta_pkg::kind_t  kind;
    fcta_pkg::level_t level;
    logic [15:0]      ttc;
    logic [13:0]      dist_cm;
    logic [31:0]      ident;
  } alert_t;

  typedef struct {
    encounter_t w;
    bit         quiet;   // alert is known to be all zero
  } directed_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [23:0] in_own_x, in_own_y, in_peer_x, in_peer_y;
  logic [15:0] in_own_heading, in_peer_heading;
  logic [13:0] in_own_speed, in_peer_speed;
  logic signed [13:0] in_peer_accel;
  logic [31:0] in_peer_ident;
  logic [1:0]  out_alert_kind, out_alert_level;
  logic [15:0] out_ttc_ms;
  logic [13:0] out_distance_cm;
  logic [31:0] out_alert_peer_ident;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  logic [15:0]   reg_shadow [fcta_pkg::NREG];
  alert_t        pending_alerts [$];
  directed_row_t directed_rows [$];
  int            mismatch_count;
  int            send_gap_pct, stall_pct;
  int            cycle_count;

  forward_collision_ttc_alert i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [16:0] fold_angle(logic [15:0] a);
    return (a <= 16'h8000) ? {1'b0, a} : 17'h10000 - {1'b0, a};
  endfunction

  // Line-of-sight bearing by vectoring, north zero clockwise, 2^32 per turn.
  function automatic logic [31:0] sight_bearing(longint east, longint north);
    longint x, y, z, xs, ys;
    x = north * (64'sd1 << 20);
    y = east * (64'sd1 << 20);
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sh80000000;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end
    end
    return z[31:0];
  endfunction

  function automatic longint cos_q30(logic [31:0] a);
    longint x, y, z, xs, ys;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (a >= 32'h40000000 && a < 32'hC0000000) begin
      a = a - 32'h80000000;
      flip = 1'b1;
    end
    z = (a < 32'h80000000) ? longint'(a) : longint'(a) - (64'sd1 <<< 32);
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end else begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end
    end
    return flip ? -x : x;
  endfunction

  function automatic alert_t predict_alert(encounter_t w);
    alert_t r;
    longint dx, dy, c_own, c_peer, closing, brake_lim;
    longint unsigned d2, d, ttc;
    logic [31:0] b32, rounded;
    logic [15:0] cone;
    fcta_pkg::kind_t k;
    r = '0;
    k = fcta_pkg::KIND_NONE;
    // drop a moving peer on a different heading
    if (w.ps >= 100 && fold_angle(w.oh - w.ph) > reg_shadow[fcta_pkg::REG_HEADING]) return r;
    dx = longint'(w.px) - longint'(w.ox);
    dy = longint'(w.py) - longint'(w.oy);
    d2 = dx * dx + dy * dy;
    if (d2 < 2500 || d2 > 100000000) return r;
    d = int_sqrt(d2);
    b32 = sight_bearing(dx, dy);
    rounded = b32 + 32'h8000;
    cone = (d < reg_shadow[fcta_pkg::REG_NEAR_RANGE]) ? reg_shadow[fcta_pkg::REG_CONE_NEAR]
                                                      : reg_shadow[fcta_pkg::REG_CONE_FAR];
    if (fold_angle(rounded[31:16] - w.oh) > cone) return r;
    c_own   = cos_q30({w.oh, 16'h0} - b32);
    c_peer  = cos_q30({w.ph, 16'h0} - b32);
    closing = longint'(w.os) * c_own - longint'(w.ps) * c_peer;
    brake_lim = longint'($signed(reg_shadow[fcta_pkg::REG_BRAKE][13:0]));
    if (longint'(w.pa) < brake_lim) begin
      if (closing > 0) k = fcta_pkg::KIND_BRAKE;
    end else if (closing > (64'sd50 <<< 30)) begin
      k = fcta_pkg::KIND_TTC;
    end
    if (k == fcta_pkg::KIND_NONE) return r;
    ttc = ((d * 1000) << 30) / longint'(closing);
    if (ttc > 65535) ttc = 65535;
    if (ttc < reg_shadow[fcta_pkg::REG_TTC_CRIT])      r.level = fcta_pkg::LVL_CRIT;
    else if (ttc < reg_shadow[fcta_pkg::REG_TTC_WARN]) r.level = fcta_pkg::LVL_WARN;
    else if (ttc < reg_shadow[fcta_pkg::REG_TTC_INFO]) r.level = fcta_pkg::LVL_INFO;
    else return '0;
    r.kind    = k;
    r.ttc     = ttc[15:0];
    r.dist_cm = (d > 16383) ? 14'd16383 : d[13:0];
    r.ident   = w.ident;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_row(int ox, int oy, int oh, int os, int px, int py, int ph,
                                  int ps, int pa, logic [31:0] ident, bit quiet);
    directed_row_t row;
    row.w = '{24'(ox), 24'(oy), 16'(oh), 14'(os), 24'(px), 24'(py), 16'(ph), 14'(ps),
              14'(pa), ident};
    row.quiet = quiet;
    directed_rows.push_back(row);
  endfunction

  // Mostly a peer placed ahead in range on a similar heading; the rest is noise.
  function automatic encounter_t make_encounter();
    encounter_t w;
    real th;
    int  r, off;
    w.ox = 24'($urandom); w.oy = 24'($urandom);
    w.oh = 16'($urandom);
    w.pa = 14'($urandom);
    w.ident = $urandom;
    if ($urandom_range(99) < 20) begin
      w.px = 24'($urandom); w.py = 24'($urandom);
      w.ph = 16'($urandom);
      w.os = 14'($urandom); w.ps = 14'($urandom);
      return w;
    end
    r   = ($urandom_range(3) == 0) ? $urandom_range(30, 10100) : $urandom_range(40, 2500);
    off = $urandom_range(24000) - 12000;
    th  = real'(int'(w.oh) + off) * 6.283185307179586 / 65536.0;
    w.px = w.ox + 24'($rtoi(r * $sin(th)));
    w.py = w.oy + 24'($rtoi(r * $cos(th)));
    w.ph = w.oh + 16'($urandom_range(24000) - 12000);
    w.os = 14'($urandom_range(10000));
    w.ps = ($urandom_range(9) < 3) ? 14'($urandom_range(99)) : 14'($urandom_range(10000));
    return w;
  endfunction

  task automatic send_word(encounter_t w, bit quiet);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_own_x        = w.ox;
    in_own_y        = w.oy;
    in_own_heading  = w.oh;
    in_own_speed    = w.os;
    in_peer_x       = w.px;
    in_peer_y       = w.py;
    in_peer_heading = w.ph;
    in_peer_speed   = w.ps;
    in_peer_accel   = w.pa;
    in_peer_ident   = w.ident;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_alerts.push_back(quiet ? alert_t'('0) : predict_alert(w));
    @(negedge clk);
  endtask

  // Wait for every result, then let the pipeline empty before touching registers.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_alerts.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic load_cfg(input logic [15:0] v [fcta_pkg::NREG]);
    for (int i = 0; i < fcta_pkg::NREG; i++) begin
      cfg_we    = 1'b1;
      cfg_index = 3'(i);
      cfg_data  = v[i];
      reg_shadow[i] = (fcta_pkg::reg_idx_t'(i) == fcta_pkg::REG_NEAR_RANGE ||
                       fcta_pkg::reg_idx_t'(i) == fcta_pkg::REG_BRAKE)
                      ? {2'b00, v[i][13:0]} : v[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) send_word(make_encounter(), 1'b0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("t=%0t %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Receiver holds off at random according to the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    alert_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_alerts.size() == 0) begin
        note_mismatch("unexpected word", out_alert_peer_ident, 0);
      end else begin
        e = pending_alerts.pop_front();
        if (out_alert_kind !== e.kind) note_mismatch("alert_kind", out_alert_kind, e.kind);
        if (out_alert_level !== e.level)
          note_mismatch("alert_level", out_alert_level, e.level);
        if (out_ttc_ms !== e.ttc) note_mismatch("ttc_ms", out_ttc_ms, e.ttc);
        if (out_distance_cm !== e.dist_cm)
          note_mismatch("distance_cm", out_distance_cm, e.dist_cm);
        if (out_alert_peer_ident !== e.ident)
          note_mismatch("alert_peer_ident", out_alert_peer_ident, e.ident);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_own_x = '0; in_own_y = '0; in_own_heading = '0; in_own_speed = '0;
    in_peer_x = '0; in_peer_y = '0; in_peer_heading = '0; in_peer_speed = '0;
    in_peer_accel = '0; in_peer_ident = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_gap_pct = 6;
    stall_pct = 55;
    reg_shadow = '{16'd2731, 16'd8192, 16'd1000, 16'd8192, 16'(16384 - 400),
                   16'd1500, 16'd3000, 16'd5000};

    // Directed words under the reset registers; own vehicle faces north unless noted.
    add_row(0, 0, 0, 1000, 0, 2000, 32768, 500, 0, 32'h1, 1);        // moving, wrong heading
    add_row(0, 0, 0, 2000, 0, 2000, 32768, 50, 0, 32'h2, 0);         // stationary skips heading
    add_row(0, 0, 0, 1000, 0, 49, 0, 0, 0, 32'h3, 1);                // too close
    add_row(0, 0, 0, 1000, 0, 50, 0, 0, 0, 32'h4, 0);                // closest allowed
    add_row(0, 0, 0, 10000, 0, 10000, 0, 0, 0, 32'h5, 0);            // range limit
    add_row(0, 0, 0, 10000, 0, 10001, 0, 0, 0, 32'h6, 1);            // just out of range
    add_row(0, 0, 0, 3000, 2000, 2000, 0, 0, 0, 32'h7, 1);           // outside far cone
    add_row(0, 0, 0, 3000, 500, 500, 0, 0, 0, 32'h8, 0);             // near cone edge
    add_row(0, 0, 0, 300, 0, 1000, 0, 0, -8192, 32'h9, 0);           // hard braking, slow
    add_row(0, 0, 0, 0, 0, 1000, 0, 0, -8192, 32'hA, 1);             // braking, no approach
    add_row(0, 0, 0, 100, 0, 1000, 0, 0, 0, 32'hB, 1);               // TTC beyond info
    add_row(-8388608, -8388608, 65535, 16383, 8388607, 8388607, 65535, 16383, 8191,
            32'hFFFFFFFF, 1);                                        // field extremes, far off
    add_row(-8388608, -8388608, 0, 4000, -8388608, -8385608, 0, 0, 8191,
            32'hFFFFFFFF, 0);                                        // extreme corner
    add_row(0, 0, 0, 50, 0, 1000, 0, 0, 0, 32'hC, 0);                // approach about 50 cm/s
    add_row(0, 0, 65535, 9000, 0, 3000, 65535, 16383, 0, 32'h0, 0);  // faster peer, no approach
    add_row(100, 100, 32768, 3000, 100, -2900, 32768, 0, 0, 32'h5A5A5A5A, 0); // facing south
    add_row(0, 0, 16384, 6000, 2500, 0, 16384, 1000, -401, 32'hD, 0);          // facing east

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) send_word(directed_rows[i].w, directed_rows[i].quiet);
    run_random(RAND_PER_PHASE);
    drain();

    // Widest registers: every cone and heading passes, every TTC below 65535 alerts.
    load_cfg('{16'd32768, 16'd65535, 16'd16383, 16'd32768, 16'hE000,
               16'd65535, 16'd65535, 16'd65535});
    run_random(RAND_PER_PHASE);
    drain();

    send_gap_pct = 55;
    stall_pct = 6;
    load_cfg('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    run_random(RAND_PER_PHASE);
    drain();

    load_cfg('{16'($urandom_range(32768)), 16'($urandom_range(32768)),
               16'($urandom_range(16383)), 16'($urandom_range(32768)),
               16'(-$urandom_range(8192)), 16'($urandom_range(4000)),
               16'($urandom_range(8000)), 16'($urandom_range(65535))});
    run_random(RAND_PER_PHASE);
    drain();

    send_gap_pct = 0;
    stall_pct = 0;
    load_cfg('{16'd2731, 16'd8192, 16'd1000, 16'd8192, 16'(-400),
               16'd1500, 16'd3000, 16'd5000});
    run_random(RAND_PER_PHASE);
    drain();

    load_cfg('{16'd1000, 16'd16000, 16'd5000, 16'd4000, 16'(-100),
               16'd3000, 16'd6000, 16'd20000});
    run_random(RAND_PER_PHASE);
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ forward_collision_ttc_alert.f @@
rtl/core/fcta_pkg.sv
rtl/core/fcta_delay.sv
rtl/core/fcta_isqrt.sv
rtl/core/fcta_cordic_vec.sv
rtl/core/fcta_cordic_cos.sv
rtl/core/fcta_div.sv
rtl/core/forward_collision_ttc_alert.sv
rtl/core/fcta_checker.sv
tb/tb_forward_collision_ttc_alert.sv
